// ----- design/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define P22_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define P22_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define P22_ASSERT(label, clk, rst_n, prop)

`define P22_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/p22_pkg.sv -----
package p22_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIM_BITS      = 11;
  localparam int PLANE_BITS    = 16;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(1024);
  localparam logic [PLANE_BITS-1:0] PLANES_RESET = PLANE_BITS'(1);
  localparam logic [DIM_BITS-1:0]   DIM_MIN      = DIM_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PLANE_COUNT  = 2'd2,
    REG_POOL_KIND    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    POOL_MAX = 1'b0,
    POOL_AVG = 1'b1
  } pool_kind_e;

  // effective settings after clamping
  typedef struct packed {
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   height;
    logic [PLANE_BITS-1:0] planes;
    pool_kind_e            kind;
  } cfg_t;

  // scan position of the next beat and the flags it would carry
  typedef struct packed {
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;
    logic                plane_done;
    logic                tensor_done;
  } pos_t;

endpackage

// ----- design/p22_ifs.sv -----
interface p22_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [p22_pkg::CFG_IDX_BITS-1:0]  index;
  logic [p22_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface p22_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface p22_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic                          plane_done;
  logic                          tensor_done;

  modport source (output valid, pooled_value, plane_done, tensor_done, input ready);
  modport sink (input valid, pooled_value, plane_done, tensor_done, output ready);
endinterface

// ----- design/pool_2x2_stride2_core.sv -----
// 2x2 stride-2 pooling over a raster stream of samples, one or more planes.
// cfg_i: register writes (0 frame width, 1 frame height, 2 plane count,
//   3 pool kind), always ready; write only while the block is idle.
// in_i: one sample per beat, row by row, plane after plane.
// out_o: one beat per 2x2 window, carrying the max or floor average and
//   the end of plane and end of tensor flags.
// Throughput: one sample per cycle sustained while out_o.ready holds.
//   Each sample needs one compare or add and at most one access to the
//   single-port pair line memory. The window result of the bottom-right
//   sample passes the memory read stage, then the output register.
// Reset clears the scan position, the held left sample and the pipeline
//   valids; the pair line memory is not cleared and needs no clearing pass.
// When the receiver stalls, the output register and the read stage fill,
//   and input ready drops only once both hold a window result.
`include "assert_macros.svh"

module pool_2x2_stride2_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  p22_cfg_if.sink    cfg_i,
  p22_in_if.sink     in_i,
  p22_out_if.source  out_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_BITS  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int PAIR_BITS  = SAMPLE_BITS + 1;
  localparam int WIN_BITS   = SAMPLE_BITS + 2;

  p22_pkg::cfg_t cfg;
  p22_pkg::pos_t pos;

  logic in_fire, s1_go;
  logic odd_col, odd_row, mem_we, mem_re;
  logic [ADDR_BITS-1:0] slot;

  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [PAIR_BITS-1:0]   pair;
  logic [PAIR_BITS-1:0]          line_rd;

  logic                        s1_valid_q, s1_valid_d;
  logic signed [PAIR_BITS-1:0] s1_pair_q;
  logic                        s1_pdone_q, s1_tdone_q;

  logic signed [WIN_BITS-1:0]    win_a, win_b, win_comb, win_val;
  logic signed [SAMPLE_BITS-1:0] win_sat;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic                          out_pdone_q, out_tdone_q;

  p22_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  p22_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_fire),
    .pos_o  (pos)
  );

  // handshake: the read stage drains whenever the output register can load
  assign s1_go      = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_fire    = in_i.valid && in_i.ready;

  assign odd_col = pos.col[0];
  assign odd_row = pos.row[0];
  assign slot    = ADDR_BITS'(pos.col >> 1);
  assign mem_we  = in_fire && odd_col && !odd_row;
  assign mem_re  = in_fire && odd_col && odd_row;

  // horizontal pair reduction
  always_comb begin
    if (cfg.kind == p22_pkg::POOL_AVG) begin
      pair = PAIR_BITS'(left_q) + PAIR_BITS'(in_i.sample);
    end else begin
      pair = (left_q > in_i.sample) ? PAIR_BITS'(left_q) : PAIR_BITS'(in_i.sample);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (in_fire && !odd_col) begin
      left_q <= in_i.sample;
    end
  end

  // write on even rows and read on odd rows, so the port is never shared and
  // a read always lands at least one full row after the matching write
  p22_line_mem #(
    .DEPTH     (PAIR_DEPTH),
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (PAIR_BITS)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (slot),
    .wr_data_i (pair),
    .rd_en_i   (mem_re),
    .rd_addr_i (slot),
    .rd_data_o (line_rd)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (mem_re) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_pair_q  <= pair;
      s1_pdone_q <= pos.plane_done;
      s1_tdone_q <= pos.tensor_done;
    end
  end

  // vertical combine, floor quarter in average mode, and saturation
  always_comb begin
    win_a = WIN_BITS'($signed(line_rd));
    win_b = WIN_BITS'(s1_pair_q);
    if (cfg.kind == p22_pkg::POOL_AVG) begin
      win_comb = win_a + win_b;
      win_val  = win_comb >>> 2;
    end else begin
      win_comb = (win_a > win_b) ? win_a : win_b;
      win_val  = win_comb;
    end
    if ((win_val[WIN_BITS-1:SAMPLE_BITS-1] == '0) ||
        (win_val[WIN_BITS-1:SAMPLE_BITS-1] == '1)) begin
      win_sat = win_val[SAMPLE_BITS-1:0];
    end else if (win_val[WIN_BITS-1]) begin
      win_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      win_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign out_valid_d = s1_go ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_valid_q) begin
      out_value_q <= win_sat;
      out_pdone_q <= s1_pdone_q;
      out_tdone_q <= s1_tdone_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pooled_value = out_value_q;
  assign out_o.plane_done   = out_pdone_q;
  assign out_o.tensor_done  = out_tdone_q;

  `P22_ASSERT(a_s1_holds_when_stalled, clk_i, rst_ni, (s1_valid_q && !s1_go) |=> s1_valid_q)
  `P22_NEVER(a_no_accept_into_full_stage, clk_i, rst_ni, in_fire && s1_valid_q && !s1_go)
  `P22_NEVER(a_single_port_access, clk_i, rst_ni, mem_we && mem_re)
  `P22_ASSERT(a_tensor_implies_plane, clk_i, rst_ni, (out_valid_q && out_tdone_q) |-> out_pdone_q)

endmodule

// ----- design/p22_cfg_regs.sv -----
module p22_cfg_regs #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  p22_cfg_if.sink        cfg_i,
  output p22_pkg::cfg_t  cfg_o
);

  logic [p22_pkg::DIM_BITS-1:0]   width_q, width_d;
  logic [p22_pkg::DIM_BITS-1:0]   height_q, height_d;
  logic [p22_pkg::PLANE_BITS-1:0] planes_q, planes_d;
  p22_pkg::pool_kind_e            kind_q, kind_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    planes_d = planes_q;
    kind_d   = kind_q;
    if (cfg_i.valid) begin
      unique case (p22_pkg::cfg_reg_e'(cfg_i.index))
        p22_pkg::REG_FRAME_WIDTH:  width_d  = cfg_i.data[p22_pkg::DIM_BITS-1:0];
        p22_pkg::REG_FRAME_HEIGHT: height_d = cfg_i.data[p22_pkg::DIM_BITS-1:0];
        p22_pkg::REG_PLANE_COUNT:  planes_d = cfg_i.data[p22_pkg::PLANE_BITS-1:0];
        p22_pkg::REG_POOL_KIND:    kind_d   = p22_pkg::pool_kind_e'(cfg_i.data[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= p22_pkg::WIDTH_RESET;
      height_q <= p22_pkg::HEIGHT_RESET;
      planes_q <= p22_pkg::PLANES_RESET;
      kind_q   <= p22_pkg::POOL_MAX;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      planes_q <= planes_d;
      kind_q   <= kind_d;
    end
  end

  // clamp to the supported frame and treat zero planes as one
  always_comb begin
    if (width_q < p22_pkg::DIM_MIN) begin
      cfg_o.width = p22_pkg::DIM_MIN;
    end else if (int'(width_q) > MAX_WIDTH) begin
      cfg_o.width = p22_pkg::DIM_BITS'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q < p22_pkg::DIM_MIN) begin
      cfg_o.height = p22_pkg::DIM_MIN;
    end else if (int'(height_q) > MAX_HEIGHT) begin
      cfg_o.height = p22_pkg::DIM_BITS'(MAX_HEIGHT);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.planes = (planes_q == '0) ? p22_pkg::PLANE_BITS'(1) : planes_q;
    cfg_o.kind   = kind_q;
  end

endmodule

// ----- design/p22_scan.sv -----
module p22_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  p22_pkg::cfg_t  cfg_i,
  input  logic           step_i,
  output p22_pkg::pos_t  pos_o
);

  logic [p22_pkg::DIM_BITS-1:0]   col_q, col_d;
  logic [p22_pkg::DIM_BITS-1:0]   row_q, row_d;
  logic [p22_pkg::PLANE_BITS-1:0] plane_q, plane_d;
  logic [p22_pkg::DIM_BITS:0]     col_inc, row_inc;
  logic [p22_pkg::PLANE_BITS:0]   plane_inc;
  logic [p22_pkg::DIM_BITS-1:0]   last_col, last_row;

  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign plane_inc = {1'b0, plane_q} + 1'b1;

  // last window ends on the odd column and row that close the last full pair
  assign last_col = {cfg_i.width[p22_pkg::DIM_BITS-1:1], 1'b0} - 1'b1;
  assign last_row = {cfg_i.height[p22_pkg::DIM_BITS-1:1], 1'b0} - 1'b1;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (step_i) begin
      if (col_inc >= {1'b0, cfg_i.width}) begin
        col_d = '0;
        if (row_inc >= {1'b0, cfg_i.height}) begin
          row_d   = '0;
          plane_d = (plane_inc >= {1'b0, cfg_i.planes}) ? '0
                                                        : plane_inc[p22_pkg::PLANE_BITS-1:0];
        end else begin
          row_d = row_inc[p22_pkg::DIM_BITS-1:0];
        end
      end else begin
        col_d = col_inc[p22_pkg::DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

  always_comb begin
    pos_o.col         = col_q;
    pos_o.row         = row_q;
    pos_o.plane_done  = (col_q == last_col) && (row_q == last_row);
    pos_o.tensor_done = pos_o.plane_done && (plane_q == (cfg_i.planes - 1'b1));
  end

endmodule

// ----- design/p22_line_mem.sv -----
module p22_line_mem #(
  parameter int DEPTH      = 512,
  parameter int ADDR_BITS  = 9,
  parameter int DATA_BITS  = 17
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  logic [DATA_BITS-1:0] wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output logic [DATA_BITS-1:0] rd_data_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
